>>> hw/rtl/sse_pkg.sv
// Package with the constants, types and cosine table function of the sine-eased stepper ramp.
`default_nettype none

package sse_pkg;

  localparam int COUNT_BITS      = 16;
  localparam int COS_TABLE_DEPTH = 256;

  localparam int STEP_W    = COUNT_BITS;
  localparam int QTR_W     = COUNT_BITS - 2;
  localparam int HALF_W    = COUNT_BITS - 1;
  localparam int DELAY_W   = 16;
  localparam int FRAC_W    = 17;
  localparam int PROD_W    = DELAY_W + FRAC_W;
  localparam int K_W       = $clog2(COS_TABLE_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(FRAC_W);

  localparam logic [FRAC_W-1:0]  Q16_ONE     = FRAC_W'(65536);
  localparam logic [DELAY_W-1:0] DELAY_FLOOR = DELAY_W'(260);
  localparam logic [DELAY_W-1:0] SLOW_RESET  = DELAY_W'(2000);
  localparam logic [DELAY_W-1:0] FAST_RESET  = DELAY_W'(260);
  localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_SLOW = 1'b0,
    REG_FAST = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_ROM,
    ST_MUL,
    ST_FIN,
    ST_EMIT
  } seq_state_t;

  // Quarter-wave cosine in Q1.16 from a Q30 Taylor series, evaluated at elaboration.
  function automatic logic [FRAC_W-1:0] cos_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    longint      sum;
    int unsigned n;
    x    = (64'(k) * PI_HALF_Q30) / 64'(COS_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (64'(sum) + (64'd1 << 13)) >> 14;
    if (q > 64'd65536) begin
      q = 64'd65536;
    end
    return q[FRAC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sse_cos_rom.sv
// Quarter-wave cosine table with a registered read port.
`default_nettype none

module sse_cos_rom (
  input  wire logic                       clk,
  input  wire logic [sse_pkg::K_W-1:0]    rd_addr,
  output logic      [sse_pkg::FRAC_W-1:0] rd_data
);
  import sse_pkg::*;

  logic [FRAC_W-1:0] rom_w [COS_TABLE_DEPTH+1];
  logic [FRAC_W-1:0] rd_data_r;

  for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_entry
    localparam logic [FRAC_W-1:0] ENTRY = cos_entry(g);
    assign rom_w[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom_w[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/stepper_sine_ease_ramp_unit.sv
// Top level of the sine-eased stepper ramp: sequencer, shared divider step and blend.
`default_nettype none

// A start item loads a move and gives no result. An advance item in the cruise phase, or
// while idle, goes from the emit state into the output register. An advance on a ramp
// step, once taken, passes through a shared compare-and-subtract unit that forms the
// Q1.16 ramp fraction one quotient bit per cycle, then the table index, the registered
// cosine table read, one 16 by 17 bit multiply, the final blend and the output
// register. The block takes no new item until the current one sits in the output
// register, and a result that waits for out_ready holds it longer. Configuration writes
// are taken only while the sequencer is idle and no input item is offered.
module stepper_sine_ease_ramp_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_opcode,
  input  wire logic [15:0]                 in_step_count,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [sse_pkg::DELAY_W-1:0] out_delay_us,
  output logic      [1:0]                  out_ramp_phase,
  output logic                             out_last_step,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [sse_pkg::DELAY_W-1:0] cfg_data
);
  import sse_pkg::*;

  seq_state_t st_r, st_nxt;

  logic [DELAY_W-1:0]   slow_r, slow_nxt;
  logic [DELAY_W-1:0]   fast_r, fast_nxt;
  phase_t               phase_r, phase_nxt;
  logic [STEP_W-1:0]    step_idx_r, step_idx_nxt;
  logic [QTR_W-1:0]     quarter_r, quarter_nxt;
  logic [HALF_W-1:0]    half_r, half_nxt;
  logic [DELAY_W-1:0]   cruise_r, cruise_nxt;

  phase_t               item_ph_r, item_ph_nxt;
  logic                 res_last_r, res_last_nxt;
  logic [DELAY_W-1:0]   res_delay_r, res_delay_nxt;
  logic [QTR_W:0]       rem_r, rem_nxt;
  logic [FRAC_W-1:0]    quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DELAY_W-1:0]   out_delay_r, out_delay_nxt;
  phase_t               out_phase_r, out_phase_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 take_w;
  logic                 emit_w;
  logic                 div_done_w;
  logic [FRAC_W-1:0]    cos_w;

  logic [QTR_W:0]       q_eff_w;
  logic                 ge_w;
  logic [QTR_W:0]       rem_sub_w;
  logic [FRAC_W-1:0]    p_w;
  logic [31:0]          kprod_w;
  logic                 slow_ge_w;
  logic [DELAY_W-1:0]   diff_w;
  logic [FRAC_W-1:0]    e_w;
  logic [PROD_W-1:0]    ceil_sum_w;
  logic [FRAC_W-1:0]    blend_w;
  logic [STEP_W-1:0]    idx_inc_w;
  logic [COUNT_BITS-1:0] count_w;

  sse_cos_rom u_cos_rom (
    .clk     (clk),
    .rd_addr (k_r),
    .rd_data (cos_w)
  );

  assign div_done_w = (div_cnt_r == DIV_CNT_W'(FRAC_W - 1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && opcode_t'(in_opcode) == OP_ADVANCE) begin
          if (phase_r == PH_ACCEL || phase_r == PH_DECEL) begin
            st_nxt = ST_DIV;
          end else begin
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done_w) begin
          st_nxt = ST_IDX;
        end
      end
      ST_IDX:  st_nxt = ST_ROM;
      ST_ROM:  st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    emit_w   = 1'b0;
    case (st_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EMIT: emit_w   = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        emit_w   = 1'b0;
      end
    endcase
  end

  assign take_w    = in_valid && in_ready;
  assign cfg_ready = (st_r == ST_IDLE) && !in_valid;

  assign q_eff_w    = (quarter_r == '0) ? (QTR_W + 1)'(1) : {1'b0, quarter_r};
  assign ge_w       = (rem_r >= q_eff_w);
  assign rem_sub_w  = ge_w ? (rem_r - q_eff_w) : rem_r;
  assign p_w        = Q16_ONE - quot_r;
  assign kprod_w    = 32'(p_w) * 32'(COS_TABLE_DEPTH) + 32'd32768;
  assign slow_ge_w  = (slow_r >= fast_r);
  assign diff_w     = slow_ge_w ? (slow_r - fast_r) : (fast_r - slow_r);
  assign e_w        = Q16_ONE - cos_w;
  assign ceil_sum_w = prod_r + PROD_W'(65535);
  assign blend_w    = slow_ge_w ? ({1'b0, fast_r} + prod_r[PROD_W-1:16])
                                : ({1'b0, fast_r} - ceil_sum_w[PROD_W-1:16]);
  assign idx_inc_w  = step_idx_r + STEP_W'(1);
  assign count_w    = in_step_count[COUNT_BITS-1:0];

  always_comb begin
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    phase_nxt     = phase_r;
    step_idx_nxt  = step_idx_r;
    quarter_nxt   = quarter_r;
    half_nxt      = half_r;
    cruise_nxt    = cruise_r;
    item_ph_nxt   = item_ph_r;
    res_last_nxt  = res_last_r;
    res_delay_nxt = res_delay_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    div_cnt_nxt   = div_cnt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_delay_nxt = out_delay_r;
    out_phase_nxt = out_phase_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_reg_t'(cfg_index) == REG_SLOW) begin
        slow_nxt = cfg_data;
      end else begin
        fast_nxt = cfg_data;
      end
    end

    if (take_w) begin
      div_cnt_nxt = '0;
      quot_nxt    = '0;
      rem_nxt     = {1'b0, step_idx_r[QTR_W-1:0]};
      item_ph_nxt = phase_r;
      if (opcode_t'(in_opcode) == OP_START) begin
        quarter_nxt = count_w[COUNT_BITS-1:2];
        half_nxt    = count_w[COUNT_BITS-1:1];
        cruise_nxt  = slow_r;
        if (count_w[COUNT_BITS-1:2] > QTR_W'(1)) begin
          phase_nxt    = PH_ACCEL;
          step_idx_nxt = STEP_W'(1);
        end else if (count_w[COUNT_BITS-1:1] != '0) begin
          phase_nxt    = PH_CRUISE;
          step_idx_nxt = '0;
        end else begin
          phase_nxt    = PH_IDLE;
          step_idx_nxt = '0;
        end
      end else begin
        case (phase_r)
          PH_ACCEL: begin
            step_idx_nxt = idx_inc_w;
            if (idx_inc_w >= STEP_W'(quarter_r)) begin
              if (half_r != '0) begin
                phase_nxt    = PH_CRUISE;
                step_idx_nxt = '0;
              end else if (quarter_r != '0) begin
                phase_nxt    = PH_DECEL;
                step_idx_nxt = STEP_W'(quarter_r);
              end else begin
                phase_nxt    = PH_IDLE;
                step_idx_nxt = '0;
              end
            end
            res_last_nxt = (idx_inc_w >= STEP_W'(quarter_r)) && half_r == '0 &&
                           quarter_r == '0;
          end
          PH_CRUISE: begin
            res_delay_nxt = cruise_r;
            step_idx_nxt  = idx_inc_w;
            res_last_nxt  = 1'b0;
            if (idx_inc_w >= STEP_W'(half_r)) begin
              if (quarter_r != '0) begin
                phase_nxt    = PH_DECEL;
                step_idx_nxt = STEP_W'(quarter_r);
              end else begin
                phase_nxt    = PH_IDLE;
                step_idx_nxt = '0;
                res_last_nxt = 1'b1;
              end
            end
          end
          PH_DECEL: begin
            res_last_nxt = (step_idx_r <= STEP_W'(1));
            if (step_idx_r != '0) begin
              step_idx_nxt = step_idx_r - STEP_W'(1);
            end
            if (step_idx_r <= STEP_W'(1)) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_IDLE: begin
            res_delay_nxt = '0;
            res_last_nxt  = 1'b0;
          end
          default: begin
            res_delay_nxt = '0;
            res_last_nxt  = 1'b0;
          end
        endcase
      end
    end

    if (st_r == ST_DIV) begin
      quot_nxt    = {quot_r[FRAC_W-2:0], ge_w};
      rem_nxt     = {rem_sub_w[QTR_W-1:0], 1'b0};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end

    if (st_r == ST_IDX) begin
      if (kprod_w[31:16] > 16'(COS_TABLE_DEPTH)) begin
        k_nxt = K_W'(COS_TABLE_DEPTH);
      end else begin
        k_nxt = kprod_w[K_W+15:16];
      end
    end

    if (st_r == ST_MUL) begin
      prod_nxt = PROD_W'(diff_w) * PROD_W'(e_w);
    end

    if (st_r == ST_FIN) begin
      if (blend_w[DELAY_W-1:0] < DELAY_FLOOR) begin
        res_delay_nxt = DELAY_FLOOR;
      end else begin
        res_delay_nxt = blend_w[DELAY_W-1:0];
      end
      if (item_ph_r == PH_ACCEL) begin
        cruise_nxt = (blend_w[DELAY_W-1:0] < DELAY_FLOOR) ? DELAY_FLOOR
                                                           : blend_w[DELAY_W-1:0];
      end
    end

    if (emit_w) begin
      out_valid_nxt = 1'b1;
      out_delay_nxt = res_delay_r;
      out_phase_nxt = item_ph_r;
      out_last_nxt  = res_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      slow_r      <= SLOW_RESET;
      fast_r      <= FAST_RESET;
      phase_r     <= PH_IDLE;
      step_idx_r  <= '0;
      quarter_r   <= '0;
      half_r      <= '0;
      cruise_r    <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      slow_r      <= slow_nxt;
      fast_r      <= fast_nxt;
      phase_r     <= phase_nxt;
      step_idx_r  <= step_idx_nxt;
      quarter_r   <= quarter_nxt;
      half_r      <= half_nxt;
      cruise_r    <= cruise_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_ph_r   <= item_ph_nxt;
    res_last_r  <= res_last_nxt;
    res_delay_r <= res_delay_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    k_r         <= k_nxt;
    prod_r      <= prod_nxt;
    out_delay_r <= out_delay_nxt;
    out_phase_r <= out_phase_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_delay_us   = out_delay_r;
  assign out_ramp_phase = out_phase_r;
  assign out_last_step  = out_last_r;

  // A ramp step never reports a delay below the floor.
  a_ramp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_phase_r == PH_ACCEL || out_phase_r == PH_DECEL)
    |-> out_delay_r >= DELAY_FLOOR)
    else $error("ramp delay below floor");

  // An advance while idle reports zero delay and is never the last step.
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_phase_r == PH_IDLE |-> out_delay_r == '0 && !out_last_r)
    else $error("idle result carries a delay or last flag");

  // The ramp fraction never exceeds one.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDX |-> quot_r <= Q16_ONE)
    else $error("ramp fraction out of range");

  // Acceleration only runs on moves long enough to have it.
  a_accel_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ACCEL |-> quarter_r > QTR_W'(1))
    else $error("accelerating on a short move");

endmodule

`default_nettype wire
